// ===== sv/ngp_pkg.sv =====
// ----------------------------------------------------------------------------
// ngp_pkg: shared types and constants for the GLL position parser
// Prefix text, character codes, coordinate scaling constants and the structs
// passed between the parser and the coordinate math.
// ----------------------------------------------------------------------------
package ngp_pkg;

  // Sentence framing
  localparam int PREFIX_LEN  = 6;
  localparam int BUF_BYTES   = 100;
  localparam logic [6:0] BYTE_LIMIT = 7'(BUF_BYTES - 1);
  localparam int FRAC_DIGITS = 4;

  // Character codes
  localparam logic [7:0] CH_NUL   = 8'h00;
  localparam logic [7:0] CH_COMMA = 8'h2C;
  localparam logic [7:0] CH_DOT   = 8'h2E;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;
  localparam logic [7:0] CH_SOUTH = 8'h53;
  localparam logic [7:0] CH_WEST  = 8'h57;

  // Field numbers of interest
  localparam logic [2:0] FLD_LAT     = 3'd2;
  localparam logic [2:0] FLD_LAT_HEM = 3'd3;
  localparam logic [2:0] FLD_LON     = 3'd4;
  localparam logic [2:0] FLD_LON_HEM = 3'd5;
  localparam logic [2:0] FLD_MAX     = 3'd7;

  // Coordinate scaling: 1e-5 degree units
  localparam int DEG_SCALE = 100000;
  localparam int FRAC_MULT = 10;
  // floor(n / 60) = floor((n >> 2) * DIV15_MAGIC >> DIV15_SHIFT), n < 2**24
  localparam int DIV15_MAGIC = 4473925;
  localparam int DIV15_SHIFT = 26;

  localparam int DEG_W  = 10;  // up to three degree digits
  localparam int FRAC_W = 14;  // up to 9999 in 1e-4 minutes
  localparam int VAL_W  = 28;

  // Expected prefix character at a position
  function automatic logic [7:0] prefix_char(input logic [2:0] idx);
    logic [7:0] c;
    case (idx)
      3'd0:    c = 8'h24;  // $
      3'd1:    c = 8'h47;  // G
      3'd2:    c = 8'h50;  // P
      3'd3:    c = 8'h47;  // G
      3'd4:    c = 8'h4C;  // L
      3'd5:    c = 8'h4C;  // L
      default: c = 8'h00;
    endcase
    return c;
  endfunction

  // Weight of the n-th fraction digit in 1e-4 minutes
  function automatic logic [9:0] frac_weight(input logic [2:0] n);
    logic [9:0] w;
    case (n)
      3'd0:    w = 10'd1000;
      3'd1:    w = 10'd100;
      3'd2:    w = 10'd10;
      3'd3:    w = 10'd1;
      default: w = 10'd0;
    endcase
    return w;
  endfunction

  // Captured coordinate, still in digit form
  typedef struct packed {
    logic              valid;   // dot seen and at least four integer chars
    logic              neg;     // hemisphere flips the sign
    logic [DEG_W-1:0]  deg;
    logic [3:0]        tens;    // minutes, tens digit
    logic [3:0]        ones;    // minutes, ones digit
    logic [FRAC_W-1:0] frac;
  } coord_t;

  // One sentence result out of the parser
  typedef struct packed {
    logic   ok;
    coord_t lat;
    coord_t lon;
  } result_t;

  // Load enables of the coordinate math stages
  typedef struct packed {
    logic a;
    logic b;
  } stage_en_t;

endpackage

// ===== sv/nmea_gll_position_parser_core.sv =====
// ----------------------------------------------------------------------------
// nmea_gll_position_parser_core: GLL sentence position parser
// Byte-wide sentence input, one position result per sentence.
// ----------------------------------------------------------------------------
// Takes one sentence character per word and accepts a word every clock while
// the result side keeps up. Each word is parsed combinationally behind an
// input register; the word flagged as last yields one result word through
// the input register, result register, two coordinate math stages with the
// divide-by-60 multiplier and output register. Stall from the result side
// backs up through these stages one by one; words other than the last keep
// flowing; a last word waits only while every stage holds a waiting result.
module nmea_gll_position_parser_core (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_valid,
  output logic                             in_stall,
  input  logic [7:0]                       in_sentence_byte,
  input  logic                             in_end_of_sentence,
  output logic                             out_valid,
  input  logic                             out_stall,
  output logic                             out_position_ok,
  output logic signed [ngp_pkg::VAL_W-1:0] out_latitude,
  output logic signed [ngp_pkg::VAL_W-1:0] out_longitude
);

  logic                in_v_r;
  logic [7:0]          byte_r;
  logic                last_r;
  logic                v0_r, va_r, vb_r, out_v_r;
  logic                ok_a_r, ok_b_r;
  logic                out_ok_r;
  logic signed [ngp_pkg::VAL_W-1:0] out_lat_r, out_lon_r;
  ngp_pkg::result_t    res;
  ngp_pkg::result_t    res_r;
  ngp_pkg::stage_en_t  en;
  logic signed [ngp_pkg::VAL_W-1:0] lat_val, lon_val;

  logic rdy_out, rdy_b, rdy_a, rdy_0, fire, in_rdy;

  // Ready chain from the output register back to the input register
  assign rdy_out = !out_v_r || !out_stall;
  assign rdy_b   = !vb_r || rdy_out;
  assign rdy_a   = !va_r || rdy_b;
  assign rdy_0   = !v0_r || rdy_a;
  assign fire    = in_v_r && (!last_r || rdy_0);
  assign in_rdy  = !in_v_r || fire;
  assign in_stall = !in_rdy;
  assign en.a    = rdy_a;
  assign en.b    = rdy_b;

  // Input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_v_r <= 1'b0;
    end else if (in_rdy) begin
      in_v_r <= in_valid;
    end
    if (in_rdy && in_valid) begin
      byte_r <= in_sentence_byte;
      last_r <= in_end_of_sentence;
    end
  end

  ngp_parser u_parser (
    .clk    (clk),
    .rst_n  (rst_n),
    .fire   (fire),
    .byte_i (byte_r),
    .last_i (last_r),
    .res    (res)
  );

  // Result register and stage valids
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v0_r    <= 1'b0;
      va_r    <= 1'b0;
      vb_r    <= 1'b0;
      out_v_r <= 1'b0;
    end else begin
      if (rdy_0)   v0_r    <= fire && last_r;
      if (rdy_a)   va_r    <= v0_r;
      if (rdy_b)   vb_r    <= va_r;
      if (rdy_out) out_v_r <= vb_r;
    end
    if (rdy_0) res_r  <= res;
    if (rdy_a) ok_a_r <= res_r.ok;
    if (rdy_b) ok_b_r <= ok_a_r;
    if (rdy_out) begin
      out_ok_r  <= ok_b_r;
      out_lat_r <= lat_val;
      out_lon_r <= lon_val;
    end
  end

  ngp_coord_calc u_lat_calc (
    .clk   (clk),
    .en    (en),
    .coord (res_r.lat),
    .ok    (res_r.ok),
    .value (lat_val)
  );

  ngp_coord_calc u_lon_calc (
    .clk   (clk),
    .en    (en),
    .coord (res_r.lon),
    .ok    (res_r.ok),
    .value (lon_val)
  );

  assign out_valid       = out_v_r;
  assign out_position_ok = out_ok_r;
  assign out_latitude    = out_lat_r;
  assign out_longitude   = out_lon_r;

  // Checks
  a_stall_only_when_full: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> (out_valid && out_stall))
    else $error("input stalled while a stage is free");

  a_not_ok_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_position_ok) |-> (out_latitude == 0 && out_longitude == 0))
    else $error("nonzero position without ok");

  a_lat_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_latitude <= 28'sd100066666 && out_latitude >= -28'sd100066666))
    else $error("latitude out of range");

endmodule

// ===== sv/ngp_parser.sv =====
// ----------------------------------------------------------------------------
// ngp_parser: per-byte sentence parser
// Checks the prefix, splits fields on commas and accumulates the latitude and
// longitude digits. Gives the sentence result in the cycle of the last word.
// ----------------------------------------------------------------------------
module ngp_parser (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             fire,
  input  logic [7:0]       byte_i,
  input  logic             last_i,
  output ngp_pkg::result_t res
);

  logic                        prefix_ok_r,   prefix_ok_nxt;
  logic [6:0]                  char_count_r,  char_count_nxt;
  logic [2:0]                  field_num_r,   field_num_nxt;
  logic                        in_field_r,    in_field_nxt;
  logic                        dot_seen_r,    dot_seen_nxt;
  logic [2:0]                  int_chars_r,   int_chars_nxt;
  logic [ngp_pkg::DEG_W-1:0]   deg_r,         deg_nxt;
  logic [3:0]                  tens_r,        tens_nxt;
  logic [3:0]                  ones_r,        ones_nxt;
  logic [ngp_pkg::FRAC_W-1:0]  frac_r,        frac_nxt;
  logic [2:0]                  frac_cnt_r,    frac_cnt_nxt;
  ngp_pkg::coord_t             lat_r,         lat_nxt;
  ngp_pkg::coord_t             lon_r,         lon_nxt;
  logic                        bad_r,         bad_nxt;

  // Next state for one accepted word
  always_comb begin
    logic            is_digit;
    logic [3:0]      dig;
    logic            end_fld;
    ngp_pkg::coord_t cap;

    prefix_ok_nxt  = prefix_ok_r;
    char_count_nxt = char_count_r;
    field_num_nxt  = field_num_r;
    in_field_nxt   = in_field_r;
    dot_seen_nxt   = dot_seen_r;
    int_chars_nxt  = int_chars_r;
    deg_nxt        = deg_r;
    tens_nxt       = tens_r;
    ones_nxt       = ones_r;
    frac_nxt       = frac_r;
    frac_cnt_nxt   = frac_cnt_r;
    lat_nxt        = lat_r;
    lon_nxt        = lon_r;
    bad_nxt        = bad_r;
    end_fld        = 1'b0;
    is_digit       = (byte_i >= ngp_pkg::CH_ZERO) && (byte_i <= ngp_pkg::CH_NINE);
    dig            = byte_i[3:0];

    if (char_count_r < ngp_pkg::BYTE_LIMIT) begin
      if (byte_i == ngp_pkg::CH_NUL) begin
        // zero byte ends the usable data
        if (char_count_r < 7'(ngp_pkg::PREFIX_LEN)) prefix_ok_nxt = 1'b0;
        char_count_nxt = ngp_pkg::BYTE_LIMIT;
      end else begin
        if (char_count_r < 7'(ngp_pkg::PREFIX_LEN) &&
            byte_i != ngp_pkg::prefix_char(char_count_r[2:0])) begin
          prefix_ok_nxt = 1'b0;
        end
        char_count_nxt = char_count_r + 7'd1;
        if (byte_i == ngp_pkg::CH_COMMA) begin
          end_fld      = in_field_r;
          in_field_nxt = 1'b0;
        end else begin
          // field start: advance field number, clear digits, note the hemisphere
          if (!in_field_r) begin
            if (field_num_r < ngp_pkg::FLD_MAX) field_num_nxt = field_num_r + 3'd1;
            in_field_nxt  = 1'b1;
            dot_seen_nxt  = 1'b0;
            int_chars_nxt = 3'd0;
            deg_nxt       = '0;
            tens_nxt      = 4'd0;
            ones_nxt      = 4'd0;
            frac_nxt      = '0;
            frac_cnt_nxt  = 3'd0;
            if (field_num_nxt == ngp_pkg::FLD_LAT_HEM && byte_i == ngp_pkg::CH_SOUTH) begin
              lat_nxt.neg = 1'b1;
            end
            if (field_num_nxt == ngp_pkg::FLD_LON_HEM && byte_i == ngp_pkg::CH_WEST) begin
              lon_nxt.neg = 1'b1;
            end
          end
          // coordinate digits
          if (field_num_nxt == ngp_pkg::FLD_LAT || field_num_nxt == ngp_pkg::FLD_LON) begin
            if (byte_i == ngp_pkg::CH_DOT && !dot_seen_nxt) begin
              dot_seen_nxt = 1'b1;
            end else if (is_digit) begin
              if (!dot_seen_nxt) begin
                if (int_chars_nxt >= 3'd5) begin
                  bad_nxt = 1'b1;
                end else begin
                  deg_nxt = ngp_pkg::DEG_W'((14'(deg_nxt) * 14'd10) + 14'(tens_nxt));
                  tens_nxt      = ones_nxt;
                  ones_nxt      = dig;
                  int_chars_nxt = int_chars_nxt + 3'd1;
                end
              end else if (frac_cnt_nxt < 3'(ngp_pkg::FRAC_DIGITS)) begin
                frac_nxt = frac_nxt +
                           ngp_pkg::FRAC_W'(14'(dig) * 14'(ngp_pkg::frac_weight(frac_cnt_nxt)));
                frac_cnt_nxt = frac_cnt_nxt + 3'd1;
              end
            end else begin
              bad_nxt = 1'b1;
            end
          end
        end
      end
    end

    // a field still open at the last word closes there
    if (last_i && in_field_nxt) end_fld = 1'b1;

    cap.valid = dot_seen_nxt && (int_chars_nxt >= 3'd4);
    cap.neg   = 1'b0;
    cap.deg   = deg_nxt;
    cap.tens  = tens_nxt;
    cap.ones  = ones_nxt;
    cap.frac  = frac_nxt;
    if (end_fld && field_num_nxt == ngp_pkg::FLD_LAT) begin
      cap.neg = lat_nxt.neg;
      lat_nxt = cap;
    end else if (end_fld && field_num_nxt == ngp_pkg::FLD_LON) begin
      cap.neg = lon_nxt.neg;
      lon_nxt = cap;
    end

    res.ok  = prefix_ok_nxt && (char_count_nxt >= 7'(ngp_pkg::PREFIX_LEN)) &&
              (field_num_nxt >= ngp_pkg::FLD_LON_HEM) && !bad_nxt;
    res.lat = lat_nxt;
    res.lon = lon_nxt;
  end

  // Parser state; cleared after each sentence
  always_ff @(posedge clk) begin
    if (!rst_n || (fire && last_i)) begin
      prefix_ok_r  <= 1'b1;
      char_count_r <= 7'd0;
      field_num_r  <= 3'd0;
      in_field_r   <= 1'b0;
      dot_seen_r   <= 1'b0;
      int_chars_r  <= 3'd0;
      deg_r        <= '0;
      tens_r       <= 4'd0;
      ones_r       <= 4'd0;
      frac_r       <= '0;
      frac_cnt_r   <= 3'd0;
      lat_r        <= '0;
      lon_r        <= '0;
      bad_r        <= 1'b0;
    end else if (fire) begin
      prefix_ok_r  <= prefix_ok_nxt;
      char_count_r <= char_count_nxt;
      field_num_r  <= field_num_nxt;
      in_field_r   <= in_field_nxt;
      dot_seen_r   <= dot_seen_nxt;
      int_chars_r  <= int_chars_nxt;
      deg_r        <= deg_nxt;
      tens_r       <= tens_nxt;
      ones_r       <= ones_nxt;
      frac_r       <= frac_nxt;
      frac_cnt_r   <= frac_cnt_nxt;
      lat_r        <= lat_nxt;
      lon_r        <= lon_nxt;
      bad_r        <= bad_nxt;
    end
  end

endmodule

// ===== sv/ngp_coord_calc.sv =====
// ----------------------------------------------------------------------------
// ngp_coord_calc: coordinate to 1e-5 degree conversion
// Two register stages: scale degrees and minutes, then divide the minutes
// term by 60 with a reciprocal multiply. Sign and zeroing at the output.
// ----------------------------------------------------------------------------
module ngp_coord_calc (
  input  logic                            clk,
  input  ngp_pkg::stage_en_t              en,
  input  ngp_pkg::coord_t                 coord,
  input  logic                            ok,
  output logic signed [ngp_pkg::VAL_W-1:0] value
);

  logic [26:0] degp_a_r;
  logic [21:0] quart_a_r;
  logic        neg_a_r;
  logic        keep_a_r;
  logic [26:0] degp_b_r;
  logic [17:0] quot_b_r;
  logic        neg_b_r;
  logic        keep_b_r;

  logic [6:0]  mins;
  logic [23:0] num;
  logic [44:0] prod;
  logic [27:0] mag;

  // Stage A: degrees * 1e5 and minutes numerator
  assign mins = 7'((7'(coord.tens) * 7'd10) + 7'(coord.ones));
  assign num  = (24'(mins) * 24'(ngp_pkg::DEG_SCALE)) +
                (24'(coord.frac) * 24'(ngp_pkg::FRAC_MULT));

  always_ff @(posedge clk) begin
    if (en.a) begin
      degp_a_r  <= 27'(coord.deg) * 27'(ngp_pkg::DEG_SCALE);
      quart_a_r <= num[23:2];
      neg_a_r   <= coord.neg;
      keep_a_r  <= ok && coord.valid;
    end
  end

  // Stage B: divide by 15 after the shift by 2
  assign prod = 45'(quart_a_r) * 45'(ngp_pkg::DIV15_MAGIC);

  always_ff @(posedge clk) begin
    if (en.b) begin
      degp_b_r <= degp_a_r;
      quot_b_r <= prod[ngp_pkg::DIV15_SHIFT +: 18];
      neg_b_r  <= neg_a_r;
      keep_b_r <= keep_a_r;
    end
  end

  // Final sum, sign and zero when not kept
  assign mag = 28'(degp_b_r) + 28'(quot_b_r);

  always_comb begin
    if (!keep_b_r) begin
      value = '0;
    end else if (neg_b_r) begin
      value = -$signed(mag);
    end else begin
      value = $signed(mag);
    end
  end

endmodule
